// File: sv/kpd_pkg.sv
// shared types, constants and key table for the keypad scanner
package kpd_pkg;

    // register indexes on the configuration port
    localparam logic REG_MAX_DIGITS    = 1'b0;
    localparam logic REG_RELEASE_TICKS = 1'b1;

    // register reset values
    localparam logic [4:0] MAX_DIGITS_RESET    = 5'd16;
    localparam logic [3:0] RELEASE_TICKS_RESET = 4'd3;

    // idle timer saturates here
    localparam logic [3:0] IDLE_LIMIT = 4'd15;

    // characters of interest
    localparam logic [6:0] CHAR_CLEAR = 7'h43;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_NINE  = 7'h39;

    // stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic [4:0] max_digits;
        logic [3:0] release_ticks;
    } kpd_cfg_t;

    typedef struct packed {
        logic [1:0] scan_column;
        logic [7:0] held_code;
        logic [3:0] idle_ticks;
        logic [4:0] accepted_count;
    } kpd_state_t;

    typedef struct packed {
        logic [1:0] next_column;
        logic       digit_valid;
        logic [6:0] digit_char;
        logic       clear_display;
        logic [4:0] digit_count;
    } kpd_result_t;

    // keypad layout: 1 2 3 U / 4 5 6 D / 7 8 9 R / C 0 E L, index = row*4 + column
    function automatic logic [6:0] key_char(input logic [3:0] idx);
        logic [6:0] ch;
        case (idx)
            4'd0:    ch = 7'h31;
            4'd1:    ch = 7'h32;
            4'd2:    ch = 7'h33;
            4'd3:    ch = 7'h55;
            4'd4:    ch = 7'h34;
            4'd5:    ch = 7'h35;
            4'd6:    ch = 7'h36;
            4'd7:    ch = 7'h44;
            4'd8:    ch = 7'h37;
            4'd9:    ch = 7'h38;
            4'd10:   ch = 7'h39;
            4'd11:   ch = 7'h52;
            4'd12:   ch = 7'h43;
            4'd13:   ch = 7'h30;
            4'd14:   ch = 7'h45;
            4'd15:   ch = 7'h4c;
            default: ch = 7'h31;
        endcase
        return ch;
    endfunction

endpackage

// File: sv/kpd_cfg.sv
// configuration register file on an apb-style port
module kpd_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output kpd_pkg::kpd_cfg_t  cfg
);

    logic [4:0] max_digits_reg;
    logic [3:0] release_ticks_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes, index taken from the word address bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_digits_reg    <= kpd_pkg::MAX_DIGITS_RESET;
            release_ticks_reg <= kpd_pkg::RELEASE_TICKS_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == kpd_pkg::REG_MAX_DIGITS)
                max_digits_reg <= pwdata[4:0];
            else
                release_ticks_reg <= pwdata[3:0];
        end
    end

    // read mux
    always_comb
    begin
        if (paddr[2] == kpd_pkg::REG_MAX_DIGITS)
            prdata = {27'd0, max_digits_reg};
        else
            prdata = {28'd0, release_ticks_reg};
    end

    assign cfg.max_digits    = max_digits_reg;
    assign cfg.release_ticks = release_ticks_reg;

endmodule

// File: sv/kpd_step.sv
// one scan tick: key decode, count and release timer update
module kpd_step (
    input  logic                 [3:0] rows,
    input  kpd_pkg::kpd_state_t        state,
    input  kpd_pkg::kpd_cfg_t          cfg,
    output kpd_pkg::kpd_state_t        state_next,
    output kpd_pkg::kpd_result_t       result
);

    logic [3:0] col_onehot;
    logic [7:0] code;
    logic [1:0] row_idx;
    logic [6:0] ch;
    logic       take;
    logic       press;
    logic       is_clear;
    logic       is_digit;
    logic [7:0] held_mid;
    logic [3:0] idle_mid;
    logic [4:0] count_next;

    // key code and table lookup; anything but a single row reads as the top row
    always_comb
    begin
        col_onehot = 4'b0001 << state.scan_column;
        code       = {col_onehot, rows};
        case (rows)
            4'b0010: row_idx = 2'd1;
            4'b0100: row_idx = 2'd2;
            4'b1000: row_idx = 2'd3;
            default: row_idx = 2'd0;
        endcase
        ch = kpd_pkg::key_char({row_idx, state.scan_column});
    end

    // press detection and key classification
    assign take     = (rows != 4'd0) && (state.accepted_count < cfg.max_digits);
    assign press    = take && (code != state.held_code);
    assign is_clear = press && (ch == kpd_pkg::CHAR_CLEAR);
    assign is_digit = press && (ch >= kpd_pkg::CHAR_ZERO) && (ch <= kpd_pkg::CHAR_NINE);

    // digit count
    always_comb
    begin
        if (is_clear)
            count_next = 5'd0;
        else if (is_digit)
            count_next = 5'(state.accepted_count + 5'd1);
        else
            count_next = state.accepted_count;
    end

    // held code and release timer
    always_comb
    begin
        held_mid = press ? code : state.held_code;
        idle_mid = take ? 4'd0 : state.idle_ticks;
        if (idle_mid > cfg.release_ticks)
        begin
            state_next.held_code  = 8'd0;
            state_next.idle_ticks = idle_mid;
        end
        else
        begin
            state_next.held_code  = held_mid;
            state_next.idle_ticks = (idle_mid < kpd_pkg::IDLE_LIMIT) ?
                                    4'(idle_mid + 4'd1) : idle_mid;
        end
    end

    assign state_next.scan_column    = 2'(state.scan_column + 2'd1);
    assign state_next.accepted_count = count_next;

    // result item
    assign result.next_column   = state_next.scan_column;
    assign result.digit_valid   = is_digit;
    assign result.digit_char    = is_digit ? ch : 7'd0;
    assign result.clear_display = is_clear;
    assign result.digit_count   = count_next;

endmodule

// File: sv/keypad_scan_digit_entry.sv
// keypad scanner top level: input register, scan state, result register
// an accepted input passes through the input register and then the result register
// throughput: one scan tick per cycle while m_tready holds; the state update is a single pass of kpd_step
// the input register keeps accepting while a result waits, stalling only when both are full
// reset (rst_n low, asynchronous): column 0, no held key, timer and count zero,
// max_digits 16, release_ticks 3, both stages empty
module keypad_scan_digit_entry (
    input  logic                           clk,
    input  logic                           rst_n,
    // row_bits [3:0], zero [7:4]
    input  logic [kpd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // next_column [1:0], digit_char [8:2], digit_count [13:9], zero [15:14]
    output logic [kpd_pkg::M_TDATA_W-1:0]  m_tdata,
    // digit_valid [0], clear_display [1]
    output logic [kpd_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    kpd_pkg::kpd_cfg_t    cfg;
    kpd_pkg::kpd_state_t  state_reg;
    kpd_pkg::kpd_state_t  state_next;
    kpd_pkg::kpd_result_t result_next;
    kpd_pkg::kpd_result_t result_reg;
    logic                 in_valid_reg;
    logic [3:0]           rows_reg;
    logic                 out_valid_reg;
    logic                 advance;

    kpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kpd_step u_step (
        .rows       (rows_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result_next)
    );

    // handshake: the held item moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            rows_reg <= s_tdata[3:0];
    end

    // scan state, updated once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg.digit_count, result_reg.digit_char,
                       result_reg.next_column};
    assign m_tuser  = {result_reg.clear_display, result_reg.digit_valid};

    // a tick never both emits a digit and clears
    a_digit_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(result_reg.digit_valid && result_reg.clear_display))
        else $error("digit and clear in the same result");

    // an emitted character is a decimal digit, otherwise zero
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result_reg.digit_valid ?
            (result_reg.digit_char >= kpd_pkg::CHAR_ZERO &&
             result_reg.digit_char <= kpd_pkg::CHAR_NINE) :
            (result_reg.digit_char == 7'd0)))
        else $error("bad digit character");

    // the column rotates by one on each processed tick
    a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> state_reg.scan_column == 2'($past(state_reg.scan_column) + 2'd1))
        else $error("scan column did not rotate");

    // a result reports the column that the state now holds
    a_column_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_reg.next_column == state_reg.scan_column)
        else $error("result column out of step with state");

endmodule
